/* rtl/core/range_add_max_argmax_tree_top_assert.svh */
// ----------------------------------------------------------------------------
// range add max tree assertion macros
// concurrent assertion wrappers on clk_i, with and without reset gating
// ----------------------------------------------------------------------------
`ifndef RANGE_ADD_MAX_ARGMAX_TREE_TOP_ASSERT_SVH
`define RANGE_ADD_MAX_ARGMAX_TREE_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
`define RATM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define RATM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define RATM_ASSERT(lbl, prop, msg)
`define RATM_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

/* rtl/core/ratm_pkg.sv */
// ----------------------------------------------------------------------------
// ratm_pkg
// shared constants and types of the range add max tree
// ----------------------------------------------------------------------------
package ratm_pkg;

  localparam int LEAVES_DEF = 1024;
  localparam int DATA_W     = 16;
  localparam int SLOT_W     = 10;
  localparam int DELTA_W    = 2;
  localparam int COORD_W    = 32;

  localparam logic signed [DATA_W-1:0] SAT_MAX = 16'sh7fff;
  localparam logic signed [DATA_W-1:0] SAT_MIN = 16'sh8000;

  typedef struct packed {
    logic [SLOT_W-1:0]        lo;
    logic [SLOT_W-1:0]        hi;
    logic signed [DATA_W-1:0] delta;
  } ratm_cmd_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] mx;
    logic [SLOT_W-1:0]        idx;
  } ratm_res_t;

endpackage

/* rtl/core/ratm_ram.sv */
// ----------------------------------------------------------------------------
// ratm_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module ratm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/ratm_satadd.sv */
// ----------------------------------------------------------------------------
// ratm_satadd
// shared 16-bit signed adder with saturation
// ----------------------------------------------------------------------------
module ratm_satadd
  import ratm_pkg::*;
(
  input  logic signed [DATA_W-1:0] a_i,
  input  logic signed [DATA_W-1:0] b_i,
  output logic signed [DATA_W-1:0] y_o
);

  logic signed [DATA_W:0] sum;

  assign sum = {a_i[DATA_W-1], a_i} + {b_i[DATA_W-1], b_i};

  always_comb begin
    if (sum[DATA_W] != sum[DATA_W-1]) begin
      y_o = sum[DATA_W] ? SAT_MIN : SAT_MAX;
    end else begin
      y_o = sum[DATA_W-1:0];
    end
  end

endmodule

/* rtl/core/ratm_seq.sv */
// ----------------------------------------------------------------------------
// ratm_seq
// tree walk sequencer: node store, parent stack and the shared adder
// ----------------------------------------------------------------------------
`include "range_add_max_argmax_tree_top_assert.svh"

module ratm_seq
  import ratm_pkg::*;
#(
  parameter int LEAVES = LEAVES_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cmd_valid_i,
  input  ratm_cmd_t cmd_i,
  output logic      cmd_ready_o,
  output logic      res_valid_o,
  input  logic      res_ready_i,
  output ratm_res_t res_o
);

  localparam int IW    = $clog2(LEAVES);
  localparam int NW    = IW + 1;
  localparam int NODES = 2 ** NW;
  localparam int WW    = 2 * DATA_W + 1 + IW;
  localparam int CW    = (IW > SLOT_W) ? IW : SLOT_W;
  localparam int DEPTH = IW;
  localparam int SPW   = $clog2(DEPTH + 1);
  localparam int SIW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [15:0] {
    S_CLEAR   = 16'h0001,
    S_IDLE    = 16'h0002,
    S_RD_NODE = 16'h0004,
    S_SETTLE  = 16'h0008,
    S_ND2     = 16'h0010,
    S_CA1     = 16'h0020,
    S_CA2     = 16'h0040,
    S_CB1     = 16'h0080,
    S_CB2     = 16'h0100,
    S_DECIDE  = 16'h0200,
    S_RET     = 16'h0400,
    S_CMB_RD  = 16'h0800,
    S_CMB_A   = 16'h1000,
    S_CMB_B   = 16'h2000,
    S_RD_ROOT = 16'h4000,
    S_FIN     = 16'h8000
  } state_e;

  state_e state_q, state_d;
  logic [NW-1:0]  clr_q, clr_d;
  logic [NW-1:0]  idx_q, idx_d;
  logic [IW-1:0]  tl_q, tl_d, tr_q, tr_d;
  logic [SPW-1:0] depth_q, depth_d;
  logic [CW-1:0]  lo_q, lo_d, hi_q, hi_d;
  logic signed [DATA_W-1:0] d_q, d_d;
  logic [WW-1:0]  node_q, node_d, child_q, child_d;
  logic signed [DATA_W-1:0] acc_q, acc_d, lmx_q, lmx_d;
  logic [IW-1:0]  larg_q, larg_d;
  logic [IW-1:0]  stk_tl_q [DEPTH];
  logic [IW-1:0]  stk_tr_q [DEPTH];
  logic           push;

  logic           we, re;
  logic [NW-1:0]  waddr, raddr;
  logic [WW-1:0]  wdata, rdata;

  logic signed [DATA_W-1:0] alu_a, alu_b, alu_y;
  logic signed [DATA_W-1:0] rd_mx, rd_pd, nd_pd, dfull;
  logic           rd_fr;
  logic [IW-1:0]  rd_arg, mid, ptl, ptr, pmid, rarg, root_arg;
  logic [CW-1:0]  tl_c, tr_c;
  logic           outside, full, leaf, need_push;
  logic [SPW-1:0] dm1;
  logic [CW-1:0]  arg_x;

  ratm_ram #(.WIDTH(WW), .DEPTH(NODES)) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  ratm_satadd u_alu (
    .a_i (alu_a),
    .b_i (alu_b),
    .y_o (alu_y)
  );

  assign rd_mx  = rdata[WW-1 -: DATA_W];
  assign rd_pd  = rdata[WW-DATA_W-1 -: DATA_W];
  assign rd_fr  = rdata[IW];
  assign rd_arg = rdata[IW-1:0];
  assign nd_pd  = node_q[WW-DATA_W-1 -: DATA_W];

  assign tl_c    = CW'(tl_q);
  assign tr_c    = CW'(tr_q);
  assign outside = (tr_c < lo_q) || (tl_c > hi_q);
  assign full    = (lo_q <= tl_c) && (tr_c <= hi_q);
  assign leaf    = (tl_q == tr_q);
  assign dfull   = full ? d_q : '0;
  assign need_push = !leaf && ((nd_pd != '0) || (dfull != '0));
  assign mid     = tl_q + ((tr_q - tl_q) >> 1);

  assign dm1  = depth_q - SPW'(1);
  assign ptl  = stk_tl_q[dm1[SIW-1:0]];
  assign ptr  = stk_tr_q[dm1[SIW-1:0]];
  assign pmid = ptl + ((ptr - ptl) >> 1);
  assign rarg = rd_fr ? tr_q : rd_arg;
  assign root_arg = rd_fr ? IW'(LEAVES - 1) : rd_arg;
  assign arg_x    = CW'(root_arg);

  assign cmd_ready_o = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_FIN);
  assign res_o.mx    = rd_mx;
  assign res_o.idx   = arg_x[SLOT_W-1:0];

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    idx_d   = idx_q;
    tl_d    = tl_q;
    tr_d    = tr_q;
    depth_d = depth_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    d_d     = d_q;
    node_d  = node_q;
    child_d = child_q;
    acc_d   = acc_q;
    lmx_d   = lmx_q;
    larg_d  = larg_q;
    push    = 1'b0;
    we      = 1'b0;
    re      = 1'b0;
    waddr   = idx_q;
    raddr   = idx_q;
    wdata   = '0;
    alu_a   = acc_q;
    alu_b   = dfull;
    unique case (state_q)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        wdata = {{(2 * DATA_W){1'b0}}, 1'b1, {IW{1'b0}}};
        clr_d = clr_q + NW'(1);
        if (clr_q == {NW{1'b1}}) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (cmd_valid_i) begin
          lo_d    = CW'(cmd_i.lo);
          hi_d    = CW'(cmd_i.hi);
          d_d     = cmd_i.delta;
          idx_d   = NW'(1);
          tl_d    = '0;
          tr_d    = IW'(LEAVES - 1);
          depth_d = '0;
          state_d = (cmd_i.lo <= cmd_i.hi) ? S_RD_NODE : S_RD_ROOT;
        end
      end
      S_RD_NODE: begin
        re      = 1'b1;
        state_d = S_SETTLE;
      end
      S_SETTLE: begin
        node_d  = rdata;
        alu_a   = rd_mx;
        alu_b   = rd_pd;
        acc_d   = alu_y;
        state_d = S_ND2;
      end
      S_ND2: begin
        we    = 1'b1;
        wdata = {alu_y, {DATA_W{1'b0}}, node_q[IW:0]};
        if (need_push) begin
          re      = 1'b1;
          raddr   = {idx_q[NW-2:0], 1'b0};
          state_d = S_CA1;
        end else begin
          state_d = S_DECIDE;
        end
      end
      S_CA1, S_CB1: begin
        child_d = rdata;
        alu_a   = rd_pd;
        alu_b   = nd_pd;
        acc_d   = alu_y;
        state_d = (state_q == S_CA1) ? S_CA2 : S_CB2;
      end
      S_CA2: begin
        we      = 1'b1;
        waddr   = {idx_q[NW-2:0], 1'b0};
        wdata   = {child_q[WW-1 -: DATA_W], alu_y, child_q[IW:0]};
        re      = 1'b1;
        raddr   = {idx_q[NW-2:0], 1'b1};
        state_d = S_CB1;
      end
      S_CB2: begin
        we      = 1'b1;
        waddr   = {idx_q[NW-2:0], 1'b1};
        wdata   = {child_q[WW-1 -: DATA_W], alu_y, child_q[IW:0]};
        state_d = S_DECIDE;
      end
      S_DECIDE: begin
        if (outside || full) begin
          state_d = S_RET;
        end else begin
          push    = 1'b1;
          depth_d = depth_q + SPW'(1);
          idx_d   = {idx_q[NW-2:0], 1'b0};
          tr_d    = mid;
          state_d = S_RD_NODE;
        end
      end
      S_RET: begin
        if (depth_q == '0) begin
          state_d = S_RD_ROOT;
        end else if (!idx_q[0]) begin
          idx_d   = idx_q | NW'(1);
          tl_d    = pmid + IW'(1);
          tr_d    = ptr;
          state_d = S_RD_NODE;
        end else begin
          idx_d   = idx_q >> 1;
          tl_d    = ptl;
          tr_d    = ptr;
          depth_d = dm1;
          state_d = S_CMB_RD;
        end
      end
      S_CMB_RD: begin
        re      = 1'b1;
        raddr   = {idx_q[NW-2:0], 1'b0};
        state_d = S_CMB_A;
      end
      S_CMB_A: begin
        lmx_d   = rd_mx;
        larg_d  = rd_fr ? mid : rd_arg;
        re      = 1'b1;
        raddr   = {idx_q[NW-2:0], 1'b1};
        state_d = S_CMB_B;
      end
      S_CMB_B: begin
        we = 1'b1;
        if (lmx_q > rd_mx) begin
          wdata = {lmx_q, {DATA_W{1'b0}}, 1'b0, larg_q};
        end else begin
          wdata = {rd_mx, {DATA_W{1'b0}}, 1'b0, rarg};
        end
        state_d = S_RET;
      end
      S_RD_ROOT: begin
        re      = 1'b1;
        raddr   = NW'(1);
        state_d = S_FIN;
      end
      S_FIN: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      depth_q <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      depth_q <= depth_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    tl_q    <= tl_d;
    tr_q    <= tr_d;
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    d_q     <= d_d;
    node_q  <= node_d;
    child_q <= child_d;
    acc_q   <= acc_d;
    lmx_q   <= lmx_d;
    larg_q  <= larg_d;
    if (push) begin
      stk_tl_q[depth_q[SIW-1:0]] <= tl_q;
      stk_tr_q[depth_q[SIW-1:0]] <= tr_q;
    end
  end

  `RATM_ASSERT(a_depth_bound, depth_q <= SPW'(DEPTH), "stack depth overflow")
  `RATM_ASSERT(a_busy_after_start, cmd_valid_i && cmd_ready_o |=> !cmd_ready_o,
               "ready right after a transfer")
  `RATM_ASSERT(a_root_settled, state_q == S_FIN |-> rd_pd == '0, "root pending not cleared")

endmodule

/* rtl/core/range_add_max_argmax_tree_top.sv */
// ----------------------------------------------------------------------------
// range_add_max_argmax_tree_top
// range add over a lazy max tree with arg max and best so far tracking
// ----------------------------------------------------------------------------
// channel  dir  tdata (low bit up)                                 tuser
// s_axis   in   range_low 10, range_high 10, delta 2, event_x 32    -
// m_axis   out  current_max 16, current_index 10, best_value 16,    improved
//               best_x 32, best_index 10
//
// after reset the node store is cleared, all 2 * 2**clog2(LEAVES) nodes
// (2048 at 1024 slots), before the first transfer is taken
// each event is accepted, then walks the visited nodes, pushes a lazy add to both
// children where one is pending, merges the children on the way back up and reads
// the root for the result, over the single node ram port pair and the shared adder;
// an empty range skips the walk, and no new event is taken until its result is handed on
// a finished result waits in the output register while the next event runs
// ----------------------------------------------------------------------------
`include "range_add_max_argmax_tree_top_assert.svh"

module range_add_max_argmax_tree_top
  import ratm_pkg::*;
#(
  parameter int LEAVES = LEAVES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [55:0] s_axis_tdata_i,  // range_low, range_high, delta, event_x
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [87:0] m_axis_tdata_o,  // current_max, current_index, best_value,
                                       // best_x, best_index
  output logic [0:0]  m_axis_tuser_o   // improved
);

  ratm_cmd_t cmd;
  ratm_res_t res;
  logic      res_valid, res_ready;
  logic      cmd_ready;

  logic signed [COORD_W-1:0] x_q;
  logic signed [DATA_W-1:0]  best_count_q, best_count_d;
  logic signed [COORD_W-1:0] best_coord_q, best_coord_d;
  logic [SLOT_W-1:0]         best_slot_q, best_slot_d;
  logic                      impr;
  logic                      out_valid_q;
  logic signed [DATA_W-1:0]  cur_max_q;
  logic [SLOT_W-1:0]         cur_idx_q;
  logic                      impr_q;

  assign cmd.lo    = s_axis_tdata_i[9:0];
  assign cmd.hi    = s_axis_tdata_i[19:10];
  assign cmd.delta = {{(DATA_W - DELTA_W){s_axis_tdata_i[21]}}, s_axis_tdata_i[21:20]};

  ratm_seq #(.LEAVES(LEAVES)) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (s_axis_tvalid_i),
    .cmd_i       (cmd),
    .cmd_ready_o (cmd_ready),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  assign s_axis_tready_o = cmd_ready;
  assign res_ready       = !out_valid_q || m_axis_tready_i;

  always_comb begin
    best_count_d = best_count_q;
    best_coord_d = best_coord_q;
    best_slot_d  = best_slot_q;
    impr         = 1'b0;
    if (res.mx > best_count_q) begin
      best_count_d = res.mx;
      best_coord_d = x_q;
      best_slot_d  = res.idx;
      impr         = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_count_q <= '0;
      best_coord_q <= '0;
      best_slot_q  <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        best_count_q <= best_count_d;
        best_coord_q <= best_coord_d;
        best_slot_q  <= best_slot_d;
        out_valid_q  <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && cmd_ready) begin
      x_q <= s_axis_tdata_i[53:22];
    end
    if (res_valid && res_ready) begin
      cur_max_q <= res.mx;
      cur_idx_q <= res.idx;
      impr_q    <= impr;
    end
  end

  assign m_axis_tvalid_o   = out_valid_q;
  assign m_axis_tdata_o    = {4'b0, best_slot_q, best_coord_q, best_count_q,
                              cur_idx_q, cur_max_q};
  assign m_axis_tuser_o[0] = impr_q;

  `RATM_ASSERT(a_best_nonneg, best_count_q >= 0, "best value below zero")
  `RATM_ASSERT(a_impr_value, out_valid_q && impr_q |-> best_count_q == cur_max_q,
               "improved result with stale best value")
  `RATM_ASSERT(a_impr_slot, out_valid_q && impr_q |-> best_slot_q == cur_idx_q,
               "improved result with stale best slot")

endmodule

/* verif/tb_range_add_max_argmax_tree_top.sv */
// ----------------------------------------------------------------------------
// tb_range_add_max_argmax_tree_top
// drives sweep events into the range add max tree and checks every result
// transfer field by field against a slot level prediction of the tree, with
// random idling on both streams and one long output hold-off
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_range_add_max_argmax_tree_top;
  import ratm_pkg::*;

  localparam int NSLOTS = LEAVES_DEF;

  typedef struct packed {
    logic signed [15:0] cur_max;
    logic [9:0]         cur_idx;
    logic signed [15:0] best_val;
    logic signed [31:0] best_x;
    logic [9:0]         best_idx;
    logic               improved;
  } sweep_res_t;

  class sweep_scoreboard;
    int                 slot_val[NSLOTS];
    logic signed [15:0] best_val;
    logic signed [31:0] best_x;
    logic [9:0]         best_idx;
    sweep_res_t         pending_q[$];
    int                 mismatches;
    int                 checked;
    int                 improvements;

    function new();
      foreach (slot_val[i]) slot_val[i] = 0;
      best_val = '0;
      best_x = '0;
      best_idx = '0;
      mismatches = 0;
      checked = 0;
      improvements = 0;
    endfunction

    function void note_event(logic [9:0] lo, logic [9:0] hi, logic [1:0] d,
                             logic signed [31:0] x);
      int         dv;
      int         mx;
      int         mi;
      int         v;
      sweep_res_t r;
      dv = int'($signed(d));
      if (lo <= hi) begin
        for (int i = int'(lo); i <= int'(hi); i++) begin
          v = slot_val[i] + dv;
          if (v > 32767) v = 32767;
          if (v < -32768) v = -32768;
          slot_val[i] = v;
        end
      end
      mx = slot_val[0];
      mi = 0;
      for (int i = 1; i < NSLOTS; i++) begin
        if (slot_val[i] >= mx) begin
          mx = slot_val[i];
          mi = i;
        end
      end
      r.improved = 1'b0;
      if (mx > int'(best_val)) begin
        best_val = 16'(mx);
        best_x = x;
        best_idx = 10'(mi);
        r.improved = 1'b1;
      end
      r.cur_max = 16'(mx);
      r.cur_idx = 10'(mi);
      r.best_val = best_val;
      r.best_x = best_x;
      r.best_idx = best_idx;
      pending_q.push_back(r);
    endfunction

    function void report(string fld, longint e, longint a);
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on result %0d, %s: expected %0d, got %0d", checked, fld, e, a);
    endfunction

    function void check_result(logic [87:0] data, logic [0:0] user);
      sweep_res_t e;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result with no event waiting: %h", data);
        return;
      end
      e = pending_q.pop_front();
      if ($signed(data[15:0]) != e.cur_max) report("current_max", e.cur_max, $signed(data[15:0]));
      if (data[25:16] != e.cur_idx) report("current_index", e.cur_idx, data[25:16]);
      if ($signed(data[41:26]) != e.best_val)
        report("best_value", e.best_val, $signed(data[41:26]));
      if ($signed(data[73:42]) != e.best_x) report("best_x", e.best_x, $signed(data[73:42]));
      if (data[83:74] != e.best_idx) report("best_index", e.best_idx, data[83:74]);
      if (user[0] != e.improved) report("improved", e.improved, user[0]);
      if (data[87:84] != '0) report("tdata pad", 0, data[87:84]);
      if (e.improved) improvements++;
      checked++;
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [55:0] s_axis_tdata_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [87:0] m_axis_tdata_o;
  logic [0:0]  m_axis_tuser_o;

  sweep_scoreboard sb;
  int  sent;
  bit  calm;
  int  hold_left;
  bit  hold_done;

  range_add_max_argmax_tree_top u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // one sweep event per transfer
  task automatic send_event(logic [9:0] lo, logic [9:0] hi, logic [1:0] d,
                            logic [31:0] x);
    int gap;
    s_axis_tdata_i  <= {2'b00, x, d, hi, lo};
    s_axis_tvalid_i <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_event(lo, hi, d, x);
    sent++;
    gap = (!calm && $urandom_range(99) < 34) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic random_event();
    logic [9:0] lo;
    logic [9:0] hi;
    logic [1:0] d;
    int         sel;
    sel = $urandom_range(99);
    lo = 10'($urandom);
    if (sel < 70) hi = 10'(lo + $urandom_range(0, 24));
    else if (sel < 80) hi = 10'($urandom);
    else if (sel < 85) begin
      lo = 10'($urandom_range(0, 3));
      hi = 10'($urandom_range(1020, 1023));
    end else begin
      hi = lo;
    end
    sel = $urandom_range(99);
    d = (sel < 55) ? 2'b01 : (sel < 80) ? 2'b11 : (sel < 90) ? 2'b10 : 2'b00;
    send_event(lo, hi, d, $urandom);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) sb.check_result(m_axis_tdata_o, m_axis_tuser_o);
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        m_axis_tready_i <= 1'b0;
      end else if (!hold_done && sent >= 300) begin
        hold_done <= 1'b1;
        hold_left <= 400;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= calm || ($urandom_range(99) >= 34);
      end
    end
  end

  initial begin
    #20_000_000;
    $display("timeout after %0d events sent", sent);
    $display("status: fail");
    $finish;
  end

  initial begin
    int wait_cyc;
    sb = new();
    sent = 0;
    calm = 1'b0;
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed corners
    send_event(10'd5, 10'd3, 2'b01, 32'h0000_0001);     // empty range
    send_event(10'd0, 10'd1023, 2'b11, 32'h8000_0000);  // all negative, no best
    send_event(10'd0, 10'd0, 2'b01, 32'h7fff_ffff);     // back to zero, still no best
    send_event(10'd0, 10'd0, 2'b01, 32'h7fff_ffff);     // first best at slot 0
    send_event(10'd1023, 10'd1023, 2'b01, 32'hffff_ffff);
    send_event(10'd1023, 10'd1023, 2'b01, 32'h8000_0000);
    send_event(10'd0, 10'd0, 2'b01, 32'h0000_0000);     // slot 0 alone at top again, new best
    send_event(10'd0, 10'd1023, 2'b00, 32'h1234_5678);  // zero delta
    send_event(10'd512, 10'd513, 2'b10, 32'hdead_beef); // minus two
    send_event(10'd0, 10'd1023, 2'b01, 32'h5555_5555);
    send_event(10'd0, 10'd1023, 2'b10, 32'haaaa_aaaa);
    send_event(10'd1023, 10'd0, 2'b10, 32'h0000_0002); // reversed range
    send_event(10'd511, 10'd512, 2'b01, 32'h3ff0_0001);
    send_event(10'd1023, 10'd1023, 2'b10, 32'h0000_0003);
    send_event(10'd300, 10'd700, 2'b01, 32'h7000_0000);
    send_event(10'd0, 10'd1023, 2'b11, 32'hc000_0000);
    send_event(10'd1022, 10'd1023, 2'b01, 32'h0f0f_0f0f);

    for (int i = 0; i < 690; i++) begin
      calm = (i >= 400 && i < 520);
      random_event();
    end
    calm = 1'b0;
    s_axis_tvalid_i <= 1'b0;

    wait_cyc = 0;
    while (sb.pending_q.size() != 0 && wait_cyc < 200_000) begin
      @(posedge clk_i);
      wait_cyc++;
    end
    repeat (600) @(posedge clk_i);

    $display("%0d sweep events, %0d results checked, %0d raised the best",
             sent, sb.checked, sb.improvements);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending_q.size());
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/ratm_pkg.sv
rtl/core/ratm_ram.sv
rtl/core/ratm_satadd.sv
rtl/core/ratm_seq.sv
rtl/core/range_add_max_argmax_tree_top.sv
verif/tb_range_add_max_argmax_tree_top.sv
